// ===== sv/dhfp_pkg.sv =====
package dhfp_pkg;

    // frame geometry
    localparam int WORD_W    = 32;
    localparam int MAX_WORDS = 5;
    localparam int NW_W      = 3;
    localparam int HITS_W    = 9;
    localparam int ACC_W     = 19;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_FRAMING_MODE = 1'b0;
    localparam logic REG_FORMAT_CODE  = 1'b1;

    // frame marks
    localparam logic [3:0] HEADER_MARK = 4'hA;
    localparam logic [3:0] HIT_MARK    = 4'hB;
    localparam logic [2:0] TAIL_MARK   = 3'h5;

    // word counts per item kind
    localparam logic [NW_W-1:0] NW_ONE   = 3'd1;
    localparam logic [NW_W-1:0] NW_DEBUG = 3'd4;
    localparam logic [NW_W-1:0] NW_HIT   = 3'd5;
    localparam logic [NW_W-1:0] LAST_HIT_IDX = 3'd4;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_HIT   = 2'd1,
        MODE_END   = 2'd2
    } mode_t;

    // one queued job: all words of one item
    typedef struct packed {
        logic [MAX_WORDS-1:0][WORD_W-1:0] words;
        logic [NW_W-1:0]                  nwords;
        logic                             hit;
        logic                             debug;
    } job_t;

    function automatic logic [16:0] half_sum(input logic [WORD_W-1:0] w);
        half_sum = {1'b0, w[15:0]} + {1'b0, w[31:16]};
    endfunction

endpackage

// ===== sv/dhfp_front.sv =====
module dhfp_front import dhfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [1:0]           mode,
    input  logic [6:0]           channel_address,
    input  logic [8:0]           storage_window,
    input  logic [3:0]           fine_time,
    input  logic [12:0]          peak_value,
    input  logic [15:0]          pulse_integral,
    input  logic [51:0]          edge_values,
    input  logic [15:0]          sample_timing,
    input  logic [11:0]          board_id,
    input  logic [3:0]           clock_phase,
    input  logic [15:0]          revolution_count,
    input  logic [8:0]           hit_count,
    input  logic                 framing_mode,
    input  logic [15:0]          format_code,
    output logic                 wr_en,
    output job_t                 wr_job
);

    logic [HITS_W-1:0] hits_seen_reg;
    logic [HITS_W-1:0] hits_seen_next;
    logic [11:0]       declared_words;
    logic              debug;

    assign debug = ~framing_mode;

    // 5*count+1, kept to 12 bits
    assign declared_words = {1'b0, hit_count, 2'b00} + {3'b000, hit_count} + 12'd1;

    // classify and pack
    always_comb
    begin
        wr_en          = 1'b0;
        wr_job         = '0;
        wr_job.debug   = debug;
        hits_seen_next = hits_seen_reg;
        unique case (mode_t'(mode))
            MODE_START:
            begin
                wr_en           = accept;
                wr_job.words[0] = {format_code, HEADER_MARK, board_id};
                wr_job.words[1] = {16'h0000, clock_phase, declared_words};
                wr_job.words[2] = {16'h0000, revolution_count};
                wr_job.words[3] = '0;
                wr_job.nwords   = debug ? NW_DEBUG : NW_ONE;
                if (accept)
                begin
                    hits_seen_next = '0;
                end
            end
            MODE_HIT:
            begin
                wr_en           = accept;
                wr_job.hit      = 1'b1;
                wr_job.words[0] = {channel_address, storage_window, HIT_MARK, fine_time,
                                   8'h00};
                wr_job.words[1] = {3'b000, peak_value, pulse_integral};
                wr_job.words[2] = {3'b000, edge_values[51:39], 3'b000, edge_values[38:26]};
                wr_job.words[3] = {3'b000, edge_values[25:13], 3'b000, edge_values[12:0]};
                wr_job.words[4] = {sample_timing, 16'h0000};
                wr_job.nwords   = NW_HIT;
                if (accept)
                begin
                    hits_seen_next = hits_seen_reg + 1'b1;
                end
            end
            MODE_END:
            begin
                wr_en           = accept;
                wr_job.words[0] = {20'h00000, TAIL_MARK, hits_seen_reg};
                wr_job.nwords   = NW_ONE;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // hit counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_seen_reg <= '0;
        end
        else
        begin
            hits_seen_reg <= hits_seen_next;
        end
    end

endmodule

// ===== sv/dhfp_queue.sv =====
module dhfp_queue import dhfp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    output logic full,
    output logic head_valid,
    output job_t head_job,
    input  logic rd_en
);

    job_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_wr;
    logic              do_rd;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slots_reg[rd_ptr_reg];
    assign do_wr      = wr_en && !full;
    assign do_rd      = rd_en && head_valid;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

// ===== sv/dhfp_back.sv =====
module dhfp_back import dhfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  job_t              head_job,
    output logic              rd_en,
    output logic [WORD_W-1:0] word,
    output logic              last,
    output logic              empty,
    input  logic              pop
);

    logic [NW_W-1:0]   idx_reg;
    logic [NW_W-1:0]   idx_next;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] word_reg;
    logic              last_reg;
    logic              out_ready;
    logic              send;
    logic              last_word;
    logic [WORD_W-1:0] cur_word;
    logic [WORD_W-1:0] send_word;
    logic [19:0]       total;
    logic [16:0]       fold1;
    logic [15:0]       fold2;
    logic [15:0]       checksum;

    assign out_ready = !out_valid_reg || pop;
    assign send      = head_valid && out_ready;
    assign last_word = (idx_reg == head_job.nwords - 1'b1);
    assign rd_en     = send && last_word;
    assign cur_word  = head_job.words[idx_reg];

    // checksum over the halves of the words already sent plus the top half of the last
    assign total    = {1'b0, acc_reg} + {4'h0, cur_word[31:16]};
    assign fold1    = {1'b0, total[15:0]} + {13'h0000, total[19:16]};
    assign fold2    = fold1[15:0] + {15'h0000, fold1[16]};
    assign checksum = head_job.debug ? ~fold2 : (16'h0000 - total[15:0]);

    always_comb
    begin
        send_word = cur_word;
        if (head_job.hit && (idx_reg == LAST_HIT_IDX))
        begin
            send_word = {cur_word[31:16], checksum};
        end
    end

    // word sequencer and running sum
    always_comb
    begin
        idx_next = idx_reg;
        acc_next = acc_reg;
        if (send)
        begin
            idx_next = last_word ? '0 : idx_reg + 1'b1;
            acc_next = ((idx_reg == '0) ? '0 : acc_reg) + {2'b00, half_sum(cur_word)};
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (send)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (send)
        begin
            word_reg <= send_word;
            last_reg <= last_word;
        end
    end

    assign word  = word_reg;
    assign last  = last_reg;
    assign empty = !out_valid_reg;

endmodule

// ===== sv/detector_hit_frame_packer.sv =====
// The first word of an item is registered in the queue, then in the output register.
// Words leave one per cycle while pop drains the output register; a hit has 5 words, a debug
//   header 4, others 1, through the single word-wide output register fed from the job queue.
// A four-job queue between packer and word sequencer lets input run ahead of output.
// Reset (rst_n low, asynchronous) empties the queue and output, clears the hit count
//   and returns framing_mode and format_code to zero.
module detector_hit_frame_packer import dhfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        mode,
    input  logic [6:0]        channel_address,
    input  logic [8:0]        storage_window,
    input  logic [3:0]        fine_time,
    input  logic [12:0]       peak_value,
    input  logic [15:0]       pulse_integral,
    input  logic [51:0]       edge_values,
    input  logic [15:0]       sample_timing,
    input  logic [11:0]       board_id,
    input  logic [3:0]        clock_phase,
    input  logic [15:0]       revolution_count,
    input  logic [8:0]        hit_count,
    output logic              empty,
    input  logic              pop,
    output logic [31:0]       word,
    output logic              last
);

    logic        framing_mode_reg;
    logic [15:0] format_code_reg;
    logic        cfg_wr;
    logic        accept;
    logic        q_wr_en;
    job_t        q_wr_job;
    logic        q_head_valid;
    job_t        q_head_job;
    logic        q_rd_en;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            framing_mode_reg <= 1'b0;
            format_code_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_FRAMING_MODE: framing_mode_reg <= pwdata[0];
                REG_FORMAT_CODE:  format_code_reg  <= pwdata[15:0];
                default:          framing_mode_reg <= framing_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FRAMING_MODE: prdata = {31'h0, framing_mode_reg};
            REG_FORMAT_CODE:  prdata = {16'h0000, format_code_reg};
            default:          prdata = '0;
        endcase
    end

    assign accept = push && !full;

    dhfp_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .mode             (mode),
        .channel_address  (channel_address),
        .storage_window   (storage_window),
        .fine_time        (fine_time),
        .peak_value       (peak_value),
        .pulse_integral   (pulse_integral),
        .edge_values      (edge_values),
        .sample_timing    (sample_timing),
        .board_id         (board_id),
        .clock_phase      (clock_phase),
        .revolution_count (revolution_count),
        .hit_count        (hit_count),
        .framing_mode     (framing_mode_reg),
        .format_code      (format_code_reg),
        .wr_en            (q_wr_en),
        .wr_job           (q_wr_job)
    );

    dhfp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (q_wr_en),
        .wr_job     (q_wr_job),
        .full       (full),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .rd_en      (q_rd_en)
    );

    dhfp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .rd_en      (q_rd_en),
        .word       (word),
        .last       (last),
        .empty      (empty),
        .pop        (pop)
    );

    // a full queue always has a job at its head
    a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> q_head_valid)
        else $error("queue full with no head job");

    // an accepted hit leaves a job waiting
    a_hit_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode == MODE_HIT)) |=> q_head_valid)
        else $error("accepted hit did not reach the queue");

    // a word that is not the last of its item keeps its job at the queue head
    a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !last) |-> q_head_valid)
        else $error("job left the queue before its last word");

endmodule
